// ===== design/gto_pkg.sv =====
`default_nettype none

package gto_pkg;

  localparam int unsigned POS_W         = 32;
  localparam int unsigned OFF_W         = 10;
  localparam int unsigned CFG_IDX_W     = 4;
  localparam int unsigned CFG_DATA_W    = 56;
  localparam int unsigned PATTERN_SLOTS = 16;
  localparam int unsigned DIV_STAGES    = POS_W;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 4'd0,
    REG_AMOUNT  = 4'd1,
    REG_DEPTH   = 4'd2,
    REG_TEMPO   = 4'd3,
    REG_TPQ     = 4'd4,
    REG_PAT_LEN = 4'd5,
    REG_PAT_LO  = 4'd6,
    REG_PAT_HI  = 4'd7
  } cfg_reg_e;

  localparam logic [2:0]  GROOVE_CUSTOM = 3'd6;
  localparam logic [6:0]  PV_NEUTRAL    = 7'd50;
  localparam logic [6:0]  PV_MAX        = 7'd100;
  localparam logic [8:0]  TEMPO_MIN     = 9'd20;
  localparam logic [8:0]  TEMPO_MAX     = 9'd300;
  localparam logic [8:0]  TEMPO_RST     = 9'd120;
  localparam logic [15:0] MS_PER_MIN    = 16'd60000;
  localparam logic [11:0] MS_BASE_RST   = 12'd500;

  // reciprocals for division by constant
  localparam logic [10:0] RECIP_50_A    = 11'd1311;
  localparam int unsigned RECIP_50_A_SH = 16;
  localparam logic [12:0] RECIP_100     = 13'd5243;
  localparam int unsigned RECIP_100_SH  = 19;
  localparam logic [14:0] RECIP_50_B    = 15'd20972;
  localparam int unsigned RECIP_50_B_SH = 20;

  localparam logic [6:0] FIXED_GROOVES [0:5][0:15] = '{
    '{7'd50, 7'd50, 7'd50, 7'd50, 7'd50, 7'd50, 7'd50, 7'd50,
      7'd50, 7'd50, 7'd50, 7'd50, 7'd50, 7'd50, 7'd50, 7'd50},
    '{7'd50, 7'd66, 7'd50, 7'd66, 7'd50, 7'd66, 7'd50, 7'd66,
      7'd50, 7'd66, 7'd50, 7'd66, 7'd50, 7'd66, 7'd50, 7'd66},
    '{7'd50, 7'd75, 7'd50, 7'd75, 7'd50, 7'd75, 7'd50, 7'd75,
      7'd50, 7'd75, 7'd50, 7'd75, 7'd50, 7'd75, 7'd50, 7'd75},
    '{7'd50, 7'd67, 7'd50, 7'd67, 7'd50, 7'd67, 7'd50, 7'd67,
      7'd50, 7'd67, 7'd50, 7'd67, 7'd50, 7'd67, 7'd50, 7'd67},
    '{7'd50, 7'd62, 7'd50, 7'd62, 7'd50, 7'd62, 7'd50, 7'd62,
      7'd50, 7'd62, 7'd50, 7'd62, 7'd50, 7'd62, 7'd50, 7'd62},
    '{7'd50, 7'd50, 7'd50, 7'd75, 7'd50, 7'd50, 7'd50, 7'd50,
      7'd50, 7'd50, 7'd50, 7'd75, 7'd50, 7'd50, 7'd50, 7'd50}
  };

  // fixed groove lookup, unknown codes play straight
  function automatic logic [6:0] fixed_value(input logic [2:0] groove, input logic [3:0] idx);
    logic [6:0] pv;
    pv = PV_NEUTRAL;
    if (groove < GROOVE_CUSTOM) begin
      pv = FIXED_GROOVES[groove][idx];
    end
    return pv;
  endfunction

endpackage

`default_nettype wire

// ===== design/gto_stream_if.sv =====
`default_nettype none

interface gto_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [gto_pkg::POS_W-1:0]   position;

  modport source (output valid, output op, output position, input ready);
  modport sink   (input valid, input op, input position, output ready);
endinterface

interface gto_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [gto_pkg::OFF_W-1:0] offset_ms;

  modport source (output valid, output offset_ms, input ready);
  modport sink   (input valid, input offset_ms, output ready);
endinterface

`default_nettype wire

// ===== design/groove_timing_offset_core.sv =====
// groove timing offset core: swing offset in ms for one track
//
// in_i carries an event time (op 0: sequencer ticks, op 1: milliseconds) with
// a valid/ready handshake; out_o returns one signed offset_ms per item, in order.
// configuration: cfg_we_i, cfg_idx_i and cfg_data_i write one register per
// cycle; out-of-range amount, depth and tempo values are clamped on write, unknown indexes ignored.
// a tempo write starts a divider for 60000/tempo; in_i.ready stays
// low until it finishes.
// pipeline: an accepted item passes the one-bit-per-stage 32-stage divider
// for position/subdivision, a pattern lookup stage and six multiply stages,
// then the output register.
// throughput: one item per cycle while no tempo division runs and the skid entry is empty.
// when out_o stalls, the output register plus a skid entry take the result,
// so one more item is accepted before the whole pipeline holds; nothing is
// lost or repeated.
// reset: all items are dropped and the registers return to disabled,
// straight groove, 16th resolution, 120 bpm, 96 ticks per quarter.
`default_nettype none

module groove_timing_offset_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  gto_in_if.sink                              in_i,
  gto_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [gto_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [gto_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NS  = gto_pkg::DIV_STAGES;
  localparam int unsigned NP  = 7;

  // configuration
  logic [5:0]  mode_q;
  logic [6:0]  amount_q;
  logic [6:0]  depth_q;
  logic [8:0]  tempo_q;
  logic [15:0] tpq_q;
  logic [4:0]  plen_q;
  logic [55:0] pat_lo_q;
  logic [55:0] pat_hi_q;
  logic [6:0]  amount_d;
  logic [6:0]  depth_d;
  logic [8:0]  tempo_d;

  // tempo divider
  logic        busy_q;
  logic [3:0]  tcnt_q;
  logic [8:0]  trem_q;
  logic [11:0] tquo_q;
  logic [11:0] ms_base_q;
  logic [9:0]  trem_sh_w;
  logic        tge_w;

  // derived lengths
  logic [2:0]  shift_w;
  logic [14:0] len_tick_w;
  logic [10:0] len_ms_w;
  logic [8:0]  quarter_w;

  // handshake
  logic        adv_w;
  logic        accept_w;

  // divider pipeline
  logic              dv_vld_q  [0:NS];
  logic              dv_op_q   [0:NS];
  logic              dv_zero_q [0:NS];
  logic [NS-1:0]     dv_num_q  [0:NS];
  logic [14:0]       dv_rem_q  [0:NS];
  logic [3:0]        dv_quo_q  [0:NS];
  logic [NS-1:0]     dv_num_d  [0:NS];
  logic [14:0]       dv_rem_d  [0:NS];
  logic [3:0]        dv_quo_d  [0:NS];
  logic [15:0]       dv_sh_w   [0:NS-1];
  logic [14:0]       dv_len_w  [0:NS-1];
  logic              dv_ge_w   [0:NS-1];

  // pattern pick
  logic [3:0]  idx_w;
  logic [4:0]  plen_sat_w;
  logic [4:0]  slot_rem_w;
  logic [3:0]  slot_w;
  logic [55:0] word_w;
  logic [6:0]  entry_w;
  logic [6:0]  pv_w;

  // scaling pipeline
  logic        pp_vld_q  [0:NP-1];
  logic        pp_zero_q [0:NP-1];
  logic        pp_neg_q  [0:NP-1];
  logic [5:0]  s1_mag_q;
  logic [12:0] s2_a_q;
  logic [6:0]  s3_b_q;
  logic [13:0] s4_c_q;
  logic [6:0]  s5_d_q;
  logic [15:0] s6_e_q;
  logic [9:0]  s7_f_q;
  logic [9:0]  clamp_w;
  logic signed [gto_pkg::OFF_W-1:0] fin_w;

  // output register and skid entry
  logic                             out_vld_q;
  logic signed [gto_pkg::OFF_W-1:0] out_off_q;
  logic                             skid_vld_q;
  logic signed [gto_pkg::OFF_W-1:0] skid_off_q;

  // config write clamps
  always_comb begin
    amount_d = cfg_data_i[6:0];
    if (amount_d > gto_pkg::PV_MAX) begin
      amount_d = gto_pkg::PV_MAX;
    end
    depth_d = cfg_data_i[13:7] & 7'd0;
    depth_d = cfg_data_i[6:0];
    if (depth_d > gto_pkg::PV_MAX) begin
      depth_d = gto_pkg::PV_MAX;
    end
    tempo_d = cfg_data_i[8:0];
    if (tempo_d < gto_pkg::TEMPO_MIN) begin
      tempo_d = gto_pkg::TEMPO_MIN;
    end else if (tempo_d > gto_pkg::TEMPO_MAX) begin
      tempo_d = gto_pkg::TEMPO_MAX;
    end
  end

  assign trem_sh_w = {trem_q, gto_pkg::MS_PER_MIN[tcnt_q]};
  assign tge_w     = trem_sh_w >= {1'b0, tempo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 6'd16;
      amount_q  <= 7'd50;
      depth_q   <= 7'd100;
      tempo_q   <= gto_pkg::TEMPO_RST;
      tpq_q     <= 16'd96;
      plen_q    <= 5'd0;
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      busy_q    <= 1'b0;
      tcnt_q    <= '0;
      trem_q    <= '0;
      tquo_q    <= '0;
      ms_base_q <= gto_pkg::MS_BASE_RST;
    end else begin
      if (busy_q) begin
        trem_q <= tge_w ? 9'(trem_sh_w - {1'b0, tempo_q}) : trem_sh_w[8:0];
        tquo_q <= {tquo_q[10:0], tge_w};
        tcnt_q <= tcnt_q - 4'd1;
        if (tcnt_q == 4'd0) begin
          busy_q    <= 1'b0;
          ms_base_q <= {tquo_q[10:0], tge_w};
        end
      end
      if (cfg_we_i) begin
        case (gto_pkg::cfg_reg_e'(cfg_idx_i))
          gto_pkg::REG_MODE:    mode_q   <= cfg_data_i[5:0];
          gto_pkg::REG_AMOUNT:  amount_q <= amount_d;
          gto_pkg::REG_DEPTH:   depth_q  <= depth_d;
          gto_pkg::REG_TEMPO: begin
            tempo_q <= tempo_d;
            busy_q  <= 1'b1;
            tcnt_q  <= 4'd15;
            trem_q  <= '0;
            tquo_q  <= '0;
          end
          gto_pkg::REG_TPQ:     tpq_q    <= cfg_data_i[15:0];
          gto_pkg::REG_PAT_LEN: plen_q   <= cfg_data_i[4:0];
          gto_pkg::REG_PAT_LO:  pat_lo_q <= cfg_data_i;
          gto_pkg::REG_PAT_HI:  pat_hi_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // subdivision lengths
  assign shift_w    = {1'b0, mode_q[5:4]} + 3'd1;
  assign len_tick_w = 15'(tpq_q >> shift_w);
  assign len_ms_w   = 11'(ms_base_q >> shift_w);
  assign quarter_w  = len_ms_w[10:2];

  assign adv_w      = !skid_vld_q;
  assign in_i.ready = adv_w && !busy_q;
  assign accept_w   = in_i.valid && in_i.ready;

  // restoring division, one quotient bit per stage
  always_comb begin
    dv_num_d[0] = in_i.position;
    dv_rem_d[0] = '0;
    dv_quo_d[0] = '0;
    for (int k = 0; k < NS; k++) begin
      dv_len_w[k]   = dv_op_q[k] ? {4'd0, len_ms_w} : len_tick_w;
      dv_sh_w[k]    = {dv_rem_q[k], dv_num_q[k][NS-1]};
      dv_ge_w[k]    = dv_sh_w[k] >= {1'b0, dv_len_w[k]};
      dv_rem_d[k+1] = dv_ge_w[k] ? 15'(dv_sh_w[k] - {1'b0, dv_len_w[k]}) : dv_sh_w[k][14:0];
      dv_num_d[k+1] = {dv_num_q[k][NS-2:0], 1'b0};
      dv_quo_d[k+1] = {dv_quo_q[k][2:0], dv_ge_w[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) begin
        dv_vld_q[k] <= 1'b0;
      end
    end else if (adv_w) begin
      dv_vld_q[0] <= accept_w;
      for (int k = 0; k < NS; k++) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      dv_op_q[0]   <= in_i.op;
      dv_zero_q[0] <= !mode_q[0] || (in_i.op ? (len_ms_w == '0) : (len_tick_w == '0));
      for (int k = 0; k <= NS; k++) begin
        dv_num_q[k] <= dv_num_d[k];
        dv_rem_q[k] <= dv_rem_d[k];
        dv_quo_q[k] <= dv_quo_d[k];
      end
      for (int k = 0; k < NS; k++) begin
        dv_op_q[k+1]   <= dv_op_q[k];
        dv_zero_q[k+1] <= dv_zero_q[k];
      end
    end
  end

  // pattern value for the subdivision index
  assign idx_w      = dv_quo_q[NS];
  assign plen_sat_w = (plen_q > 5'(gto_pkg::PATTERN_SLOTS)) ?
                      5'(gto_pkg::PATTERN_SLOTS) : plen_q;

  always_comb begin
    slot_rem_w = '0;
    for (int i = 3; i >= 0; i--) begin
      slot_rem_w = {slot_rem_w[3:0], idx_w[i]};
      if (slot_rem_w >= plen_sat_w) begin
        slot_rem_w = slot_rem_w - plen_sat_w;
      end
    end
  end

  assign slot_w  = slot_rem_w[3:0];
  assign word_w  = slot_w[3] ? pat_hi_q : pat_lo_q;
  assign entry_w = word_w[6'(slot_w[2:0]) * 6'd7 +: 7];

  always_comb begin
    if (mode_q[3:1] == gto_pkg::GROOVE_CUSTOM) begin
      if (plen_sat_w == '0) begin
        pv_w = gto_pkg::PV_NEUTRAL;
      end else if (entry_w > gto_pkg::PV_MAX) begin
        pv_w = gto_pkg::PV_MAX;
      end else begin
        pv_w = entry_w;
      end
    end else begin
      pv_w = gto_pkg::fixed_value(mode_q[3:1], idx_w);
    end
  end

  // scaling, all on magnitudes with the sign carried alongside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NP; k++) begin
        pp_vld_q[k] <= 1'b0;
      end
    end else if (adv_w) begin
      pp_vld_q[0] <= dv_vld_q[NS];
      for (int k = 1; k < NP; k++) begin
        pp_vld_q[k] <= pp_vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      pp_zero_q[0] <= dv_zero_q[NS];
      pp_neg_q[0]  <= pv_w < gto_pkg::PV_NEUTRAL;
      for (int k = 1; k < NP; k++) begin
        pp_zero_q[k] <= pp_zero_q[k-1];
        pp_neg_q[k]  <= pp_neg_q[k-1];
      end
      s1_mag_q <= (pv_w < gto_pkg::PV_NEUTRAL) ? 6'(gto_pkg::PV_NEUTRAL - pv_w) :
                                                 6'(pv_w - gto_pkg::PV_NEUTRAL);
      s2_a_q   <= 13'(s1_mag_q) * 13'(amount_q);
      s3_b_q   <= 7'((24'(s2_a_q) * 24'(gto_pkg::RECIP_50_A)) >> gto_pkg::RECIP_50_A_SH);
      s4_c_q   <= 14'(s3_b_q) * 14'(depth_q);
      s5_d_q   <= 7'((27'(s4_c_q) * 27'(gto_pkg::RECIP_100)) >> gto_pkg::RECIP_100_SH);
      s6_e_q   <= 16'(s5_d_q) * 16'(quarter_w);
      s7_f_q   <= 10'((31'(s6_e_q) * 31'(gto_pkg::RECIP_50_B)) >> gto_pkg::RECIP_50_B_SH);
    end
  end

  // clamp to a quarter subdivision and apply the sign
  assign clamp_w = (s7_f_q > 10'(quarter_w)) ? 10'(quarter_w) : s7_f_q;

  always_comb begin
    if (pp_zero_q[NP-1]) begin
      fin_w = '0;
    end else if (pp_neg_q[NP-1]) begin
      fin_w = -$signed(clamp_w);
    end else begin
      fin_w = $signed(clamp_w);
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!skid_vld_q) begin
      if (!out_vld_q || out_o.ready) begin
        out_vld_q <= pp_vld_q[NP-1];
      end else if (pp_vld_q[NP-1]) begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_o.ready) begin
      skid_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q) begin
      if (!out_vld_q || out_o.ready) begin
        out_off_q <= fin_w;
      end else begin
        skid_off_q <= fin_w;
      end
    end else if (out_o.ready) begin
      out_off_q <= skid_off_q;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.offset_ms = out_off_q;

`ifndef SYNTHESIS
  a_tempo_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == gto_pkg::REG_TEMPO) |=> busy_q && !in_i.ready)
    else $error("tempo write did not start the divider");

  a_ms_base_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (32'(ms_base_q) * 32'(tempo_q) <= 32'(gto_pkg::MS_PER_MIN)) &&
                (32'(ms_base_q + 12'd1) * 32'(tempo_q) > 32'(gto_pkg::MS_PER_MIN)))
    else $error("ms per beat does not match tempo");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held without an output item");

  a_skid_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |=> $stable(dv_vld_q[NS]) && $stable(pp_vld_q[NP-1]) || !skid_vld_q)
    else $error("pipeline moved while the skid entry was full");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import gto_pkg::*;

  localparam int NUM_REGS        = 8;
  localparam int MAX_SLOTS       = 16;
  localparam int PV_MID          = 50;
  localparam int PV_TOP          = 100;
  localparam int SETTLE_CYCLES   = 48;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int NUM_PHASES      = 13;
  localparam int ITEMS_PER_PHASE = 41;
  localparam int NUM_DIR         = 25;

  typedef enum logic [2:0] {
    GRV_STRAIGHT, GRV_SWING, GRV_SHUFFLE, GRV_TRIPLET,
    GRV_DOTTED, GRV_HALF, GRV_CUSTOM, GRV_UNUSED
  } groove_e;

  localparam logic [1:0] RES_8TH  = 2'd0;
  localparam logic [1:0] RES_16TH = 2'd1;
  localparam logic [1:0] RES_32ND = 2'd2;
  localparam logic [1:0] RES_64TH = 2'd3;

  typedef struct packed {
    logic [5:0]  mode;
    logic [6:0]  amount;
    logic [6:0]  depth;
    logic [8:0]  tempo;
    logic [15:0] tpq;
    logic [4:0]  plen;
    logic [55:0] plo;
    logic [55:0] phi;
  } cfg_t;

  typedef struct packed {
    cfg_t                    cfg;
    logic                    op;
    logic [POS_W-1:0]        pos;
    logic                    chk;
    logic signed [OFF_W-1:0] exp_off;
  } dir_row_t;

  localparam cfg_t CFG_RST    = '{{RES_16TH, GRV_STRAIGHT, 1'b0}, 7'd50, 7'd100, 9'd120,
                                  16'd96, 5'd0, 56'd0, 56'd0};
  localparam cfg_t CFG_SWING  = '{{RES_16TH, GRV_SWING, 1'b1}, 7'd50, 7'd100, 9'd120,
                                  16'd96, 5'd0, 56'd0, 56'd0};
  localparam cfg_t CFG_SHUF   = '{{RES_8TH, GRV_SHUFFLE, 1'b1}, 7'd100, 7'd100, 9'd300,
                                  16'd96, 5'd0, 56'd0, 56'd0};
  localparam cfg_t CFG_TRIP   = '{{RES_32ND, GRV_TRIPLET, 1'b1}, 7'd50, 7'd100, 9'd120,
                                  16'd96, 5'd0, 56'd0, 56'd0};
  localparam cfg_t CFG_DOT    = '{{RES_64TH, GRV_DOTTED, 1'b1}, 7'd75, 7'd60, 9'd20,
                                  16'd96, 5'd0, 56'd0, 56'd0};
  localparam cfg_t CFG_HALF   = '{{RES_16TH, GRV_HALF, 1'b1}, 7'd50, 7'd100, 9'd120,
                                  16'd96, 5'd0, 56'd0, 56'd0};
  localparam cfg_t CFG_G7     = '{{RES_16TH, GRV_UNUSED, 1'b1}, 7'd100, 7'd100, 9'd20,
                                  16'd96, 5'd0, 56'd0, 56'd0};
  localparam cfg_t CFG_STR    = '{{RES_8TH, GRV_STRAIGHT, 1'b1}, 7'd100, 7'd100, 9'd20,
                                  16'd96, 5'd0, 56'd0, 56'd0};
  localparam cfg_t CFG_CMAX   = '{{RES_8TH, GRV_CUSTOM, 1'b1}, 7'd100, 7'd100, 9'd20,
                                  16'd96, 5'd1, 56'd100, 56'd0};
  localparam cfg_t CFG_CMIN   = '{{RES_8TH, GRV_CUSTOM, 1'b1}, 7'd100, 7'd100, 9'd20,
                                  16'd96, 5'd1, 56'd0, 56'd0};
  localparam cfg_t CFG_CCLAMP = '{{RES_8TH, GRV_CUSTOM, 1'b1}, 7'd127, 7'd127, 9'd20,
                                  16'd96, 5'd1, 56'd127, 56'd0};
  localparam cfg_t CFG_CZERO  = '{{RES_8TH, GRV_CUSTOM, 1'b1}, 7'd100, 7'd100, 9'd20,
                                  16'd96, 5'd0, 56'd100, 56'd0};
  localparam cfg_t CFG_CSAT   = '{{RES_8TH, GRV_CUSTOM, 1'b1}, 7'd100, 7'd100, 9'd20,
                                  16'd96, 5'd31, {8{7'd10}}, {8{7'd90}}};
  localparam cfg_t CFG_TSLOW  = '{{RES_8TH, GRV_CUSTOM, 1'b1}, 7'd100, 7'd100, 9'd5,
                                  16'd96, 5'd1, 56'd100, 56'd0};
  localparam cfg_t CFG_TFAST  = '{{RES_8TH, GRV_CUSTOM, 1'b1}, 7'd100, 7'd100, 9'd511,
                                  16'd96, 5'd1, 56'd100, 56'd0};
  localparam cfg_t CFG_TPQ0   = '{{RES_16TH, GRV_SWING, 1'b1}, 7'd100, 7'd100, 9'd120,
                                  16'd0, 5'd0, 56'd0, 56'd0};
  localparam cfg_t CFG_TPQ1   = '{{RES_8TH, GRV_SWING, 1'b1}, 7'd100, 7'd100, 9'd120,
                                  16'd1, 5'd0, 56'd0, 56'd0};
  localparam cfg_t CFG_TPQMAX = '{{RES_16TH, GRV_SWING, 1'b1}, 7'd100, 7'd100, 9'd120,
                                  16'd65535, 5'd0, 56'd0, 56'd0};
  localparam cfg_t CFG_AMT0   = '{{RES_16TH, GRV_SWING, 1'b1}, 7'd0, 7'd100, 9'd120,
                                  16'd96, 5'd0, 56'd0, 56'd0};
  localparam cfg_t CFG_DEP0   = '{{RES_16TH, GRV_SWING, 1'b1}, 7'd100, 7'd0, 9'd120,
                                  16'd96, 5'd0, 56'd0, 56'd0};

  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    '{CFG_RST,    1'b0, 32'd0,          1'b1, 10'sd0},
    '{CFG_RST,    1'b1, 32'hFFFF_FFFF,  1'b1, 10'sd0},
    '{CFG_SWING,  1'b0, 32'd24,         1'b0, 10'sd0},
    '{CFG_SWING,  1'b1, 32'd125,        1'b0, 10'sd0},
    '{CFG_SWING,  1'b0, 32'hFFFF_FFFF,  1'b0, 10'sd0},
    '{CFG_SHUF,   1'b0, 32'd48,         1'b0, 10'sd0},
    '{CFG_TRIP,   1'b1, 32'd15,         1'b0, 10'sd0},
    '{CFG_DOT,    1'b1, 32'd187,        1'b0, 10'sd0},
    '{CFG_HALF,   1'b0, 32'd72,         1'b0, 10'sd0},
    '{CFG_G7,     1'b0, 32'd24,         1'b1, 10'sd0},
    '{CFG_STR,    1'b1, 32'd1500,       1'b1, 10'sd0},
    '{CFG_CMAX,   1'b1, 32'd0,          1'b1, 10'sd375},
    '{CFG_CMIN,   1'b1, 32'd0,          1'b1, -10'sd375},
    '{CFG_CCLAMP, 1'b1, 32'd0,          1'b1, 10'sd375},
    '{CFG_CZERO,  1'b1, 32'd0,          1'b1, 10'sd0},
    '{CFG_CSAT,   1'b1, 32'd13500,      1'b0, 10'sd0},
    '{CFG_CSAT,   1'b1, 32'hFFFF_FFFF,  1'b0, 10'sd0},
    '{CFG_TSLOW,  1'b1, 32'd0,          1'b1, 10'sd375},
    '{CFG_TFAST,  1'b1, 32'd0,          1'b0, 10'sd0},
    '{CFG_TPQ0,   1'b0, 32'd77,         1'b1, 10'sd0},
    '{CFG_TPQ0,   1'b1, 32'd125,        1'b0, 10'sd0},
    '{CFG_TPQ1,   1'b0, 32'd5,          1'b1, 10'sd0},
    '{CFG_TPQMAX, 1'b0, 32'hFFFF_FFFF,  1'b0, 10'sd0},
    '{CFG_AMT0,   1'b1, 32'd125,        1'b1, 10'sd0},
    '{CFG_DEP0,   1'b1, 32'd125,        1'b1, 10'sd0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  gto_in_if  in_if ();
  gto_out_if out_if ();

  groove_timing_offset_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the block's registers
  logic [5:0]  cur_mode;
  logic [6:0]  cur_amount;
  logic [6:0]  cur_depth;
  logic [8:0]  cur_tempo;
  logic [15:0] cur_tpq;
  logic [4:0]  cur_plen;
  logic [55:0] cur_plo;
  logic [55:0] cur_phi;

  logic signed [OFF_W-1:0] exp_offsets [$];
  logic signed [OFF_W-1:0] next_off;
  int                      err_count = 0;
  int                      idle_cycles = 0;
  bit                      quiet = 1'b0;

  function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_MODE:    cur_mode = d[5:0];
      REG_AMOUNT:  cur_amount = (d[6:0] > 7'd100) ? 7'd100 : d[6:0];
      REG_DEPTH:   cur_depth = (d[6:0] > 7'd100) ? 7'd100 : d[6:0];
      REG_TEMPO: begin
        cur_tempo = d[8:0];
        if (cur_tempo < 9'd20) cur_tempo = 9'd20;
        if (cur_tempo > 9'd300) cur_tempo = 9'd300;
      end
      REG_TPQ:     cur_tpq = d[15:0];
      REG_PAT_LEN: cur_plen = d[4:0];
      REG_PAT_LO:  cur_plo = d;
      REG_PAT_HI:  cur_phi = d;
      default: ;
    endcase
  endfunction

  function automatic int unsigned groove_value(logic [3:0] slot_idx);
    int unsigned plen_eff;
    int unsigned slot;
    int unsigned v;
    logic [55:0] word;
    case (cur_mode[3:1])
      GRV_SWING:   v = slot_idx[0] ? 66 : PV_MID;
      GRV_SHUFFLE: v = slot_idx[0] ? 75 : PV_MID;
      GRV_TRIPLET: v = slot_idx[0] ? 67 : PV_MID;
      GRV_DOTTED:  v = slot_idx[0] ? 62 : PV_MID;
      GRV_HALF:    v = (slot_idx[2:0] == 3'd3) ? 75 : PV_MID;
      GRV_CUSTOM: begin
        plen_eff = (cur_plen > MAX_SLOTS) ? MAX_SLOTS : cur_plen;
        if (plen_eff == 0) begin
          v = PV_MID;
        end else begin
          slot = slot_idx % plen_eff;
          word = (slot < 8) ? cur_plo : cur_phi;
          v = 32'((word >> (7 * (slot % 8))) & 56'h7F);
          if (v > PV_TOP) v = PV_TOP;
        end
      end
      default: v = PV_MID;
    endcase
    return v;
  endfunction

  function automatic logic signed [OFF_W-1:0] predict_offset(logic op_ms, logic [POS_W-1:0] pos);
    int unsigned shift;
    int unsigned ms_sub;
    int unsigned len;
    int unsigned idx;
    int          s;
    int          m;
    int          off;
    shift = 32'(cur_mode[5:4]) + 1;
    ms_sub = (32'd60000 / 32'(cur_tempo)) >> shift;
    if (!cur_mode[0]) return '0;
    len = op_ms ? ms_sub : (32'(cur_tpq) >> shift);
    if (len == 0) return '0;
    idx = (pos / len) % 16;
    s = (int'(groove_value(idx[3:0])) - PV_MID) * int'(cur_amount) / 50;
    s = s * int'(cur_depth) / 100;
    m = int'(ms_sub / 4);
    off = s * m / 50;
    if (off > m) off = m;
    if (off < -m) off = -m;
    return off[OFF_W-1:0];
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t        c;
    int          i;
    int unsigned e;
    c.mode = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 4) != 0) c.mode[0] = 1'b1;
    if ($urandom_range(0, 2) == 0) c.mode[3:1] = GRV_CUSTOM;
    c.amount = 7'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100));
    c.depth = 7'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100));
    c.tempo = 9'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 511) : $urandom_range(20, 300));
    c.tpq = 16'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 960));
    c.plen = 5'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16));
    c.plo = '0;
    c.phi = '0;
    for (i = 0; i < 16; i++) begin
      e = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100);
      if (i < 8) c.plo[7*i +: 7] = 7'(e);
      else c.phi[7*(i-8) +: 7] = 7'(e);
    end
    return c;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk);
    shadow_write(idx, d);
  endtask

  // upper data bits carry noise, the block keeps only the register width
  task automatic apply_cfg(cfg_t c);
    logic [63:0] noise;
    noise = {$urandom(), $urandom()};
    write_reg(REG_MODE,    {noise[49:0], c.mode});
    write_reg(REG_AMOUNT,  {noise[48:0], c.amount});
    write_reg(REG_DEPTH,   {noise[48:0], c.depth});
    write_reg(REG_TEMPO,   {noise[46:0], c.tempo});
    write_reg(REG_TPQ,     {noise[39:0], c.tpq});
    write_reg(REG_PAT_LEN, {noise[50:0], c.plen});
    write_reg(REG_PAT_LO,  c.plo);
    write_reg(REG_PAT_HI,  c.phi);
    write_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(0, 7)), noise[55:0]);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (exp_offsets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(logic op, logic [POS_W-1:0] pos, logic chk,
                           logic signed [OFF_W-1:0] exp_off);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.op       <= op;
    in_if.position <= pos;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    exp_offsets.push_back(chk ? exp_off : predict_offset(op, pos));
  endtask

  initial begin
    cfg_t             last_cfg;
    int               r;
    int               ph;
    int               n;
    logic [POS_W-1:0] pos;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.op       = 1'b0;
    in_if.position = '0;
    cur_mode   = CFG_RST.mode;
    cur_amount = CFG_RST.amount;
    cur_depth  = CFG_RST.depth;
    cur_tempo  = CFG_RST.tempo;
    cur_tpq    = CFG_RST.tpq;
    cur_plen   = CFG_RST.plen;
    cur_plo    = CFG_RST.plo;
    cur_phi    = CFG_RST.phi;
    last_cfg   = CFG_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < NUM_DIR; r++) begin
      if (DIR_TAB[r].cfg != last_cfg) begin
        wait_idle();
        apply_cfg(DIR_TAB[r].cfg);
        last_cfg = DIR_TAB[r].cfg;
      end
      send_item(DIR_TAB[r].op, DIR_TAB[r].pos, DIR_TAB[r].chk, DIR_TAB[r].exp_off);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      quiet = (ph % 4 == 3) || (ph >= NUM_PHASES - 2);
      apply_cfg(random_cfg());
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(0, 3))
          0: pos = $urandom();
          1: pos = $urandom_range(0, 65535);
          2: pos = $urandom_range(0, 1023);
          default: pos = 32'hFFFF_FFFF - $urandom_range(0, 4095);
        endcase
        send_item(1'($urandom_range(0, 1)), pos, 1'b0, '0);
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // result side back-pressure
  initial begin
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      out_if.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (exp_offsets.size() == 0) begin
        $display("%0t: offset_ms expected none actual %0d", $time, out_if.offset_ms);
        err_count++;
      end else begin
        next_off = exp_offsets.pop_front();
        if (out_if.offset_ms !== next_off) begin
          $display("%0t: offset_ms expected %0d actual %0d", $time, next_off,
                   out_if.offset_ms);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
